[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the maze carver.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

[hdl/rwmc_pkg.sv]
// Types and codes of the random-walk maze carver.
// No dependencies.
`timescale 1ns / 1ps
package rwmc_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] pick;
	} item_t;

	typedef struct packed {
		logic [4:0] from_row;
		logic [5:0] from_col;
		logic [4:0] to_row;
		logic [5:0] to_col;
		logic       carved;
		logic       done_res;
	} result_t;

	typedef enum logic [1:0] {
		REG_ROWS      = 2'd0,
		REG_COLS      = 2'd1,
		REG_START_ROW = 2'd2,
		REG_START_COL = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_UPDATE = 1'b1
	} ctrl_state_t;

	localparam logic MODE_START = 1'b0;

endpackage

[hdl/rwmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rwmc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/random_walk_maze_carver.sv]
// Aldous-Broder random-walk maze carver: top level, uses rwmc_pkg and rwmc_ram.
// Each transaction is accepted with its visited-row read, then updated and written back.
// Result is registered on leaving update, which result_stall can hold; no new item is taken
// before then, due to the read-modify-write of one visited-map row and the walker it moves.
// arst_n resets control state, config registers (to 30x50, start 0,0), walker, count and row valid bits;
// the visited map needs no clearing pass (per-row valid bits, cleared on start).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module random_walk_maze_carver
	import rwmc_pkg::*;
#(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RW     = $clog2(MAX_ROWS);
	localparam int CW     = $clog2(MAX_COLS);
	localparam int SRW    = $clog2(MAX_ROWS + 1);
	localparam int SCW    = $clog2(MAX_COLS + 1);
	localparam int MR_EFF = (MAX_ROWS < 63) ? MAX_ROWS : 63;
	localparam int MC_EFF = (MAX_COLS < 127) ? MAX_COLS : 127;
	localparam int CNTW   = $clog2(MR_EFF * MC_EFF + 1);
	localparam int RST_ROWS  = (MAX_ROWS < 30) ? MAX_ROWS : 30;
	localparam int RST_COLS  = (MAX_COLS < 50) ? MAX_COLS : 50;
	localparam int RST_TOTAL = RST_ROWS * RST_COLS;

	// configuration registers
	logic [5:0] rows_cfg_q;
	logic [6:0] cols_cfg_q;
	logic [4:0] start_row_cfg_q;
	logic [5:0] start_col_cfg_q;

	// walk state
	ctrl_state_t        state_q, state_d;
	logic [SRW-1:0]     maze_rows_q;
	logic [SCW-1:0]     maze_cols_q;
	logic [CNTW-1:0]    total_q;
	logic [CNTW-1:0]    count_q;
	logic [RW-1:0]      walker_row_q;
	logic [CW-1:0]      walker_col_q;
	logic [MAX_ROWS-1:0] row_valid_q;
	logic               result_valid_q;
	result_t            result_q;

	// first-stage registers
	logic               start_s1;
	logic               move_s1;
	logic               done_s1;
	logic [RW-1:0]      tr_s1;
	logic [CW-1:0]      tc_s1;
	logic [SRW-1:0]     size_r_s1;
	logic [SCW-1:0]     size_c_s1;

	logic accept, complete;

	//------------------------------------------------------------------
	// Configuration port
	//------------------------------------------------------------------
	cfg_reg_t cfg_sel;
	assign cfg_sel = cfg_reg_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q      <= 6'd30;
			cols_cfg_q      <= 7'd50;
			start_row_cfg_q <= 5'd0;
			start_col_cfg_q <= 6'd0;
		end else if (psel && penable && pwrite && pready) begin
			case (cfg_sel)
				REG_ROWS:      rows_cfg_q      <= pwdata[5:0];
				REG_COLS:      cols_cfg_q      <= pwdata[6:0];
				REG_START_ROW: start_row_cfg_q <= pwdata[4:0];
				REG_START_COL: start_col_cfg_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_ROWS:      prdata = {26'd0, rows_cfg_q};
			REG_COLS:      prdata = {25'd0, cols_cfg_q};
			REG_START_ROW: prdata = {27'd0, start_row_cfg_q};
			REG_START_COL: prdata = {26'd0, start_col_cfg_q};
			default:       prdata = 32'd0;
		endcase
	end

	//------------------------------------------------------------------
	// Control
	//------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_UPDATE;
			ST_UPDATE: if (complete) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		complete   = 1'b0;
		case (state_q)
			ST_IDLE:   item_stall = 1'b0;
			ST_UPDATE: complete   = !result_valid_q || !result_stall;
			default: ;
		endcase
	end

	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	//------------------------------------------------------------------
	// Stage 1: size clamp, neighbour choice, row read
	//------------------------------------------------------------------
	logic [SRW-1:0] clamp_r;
	logic [SCW-1:0] clamp_c;
	logic [RW-1:0]  start_r;
	logic [CW-1:0]  start_c;

	always_comb begin
		if (rows_cfg_q == 6'd0) begin
			clamp_r = SRW'(1);
		end else if (9'(rows_cfg_q) > 9'(MAX_ROWS)) begin
			clamp_r = SRW'(MAX_ROWS);
		end else begin
			clamp_r = SRW'(rows_cfg_q);
		end
		if (cols_cfg_q == 7'd0) begin
			clamp_c = SCW'(1);
		end else if (9'(cols_cfg_q) > 9'(MAX_COLS)) begin
			clamp_c = SCW'(MAX_COLS);
		end else begin
			clamp_c = SCW'(cols_cfg_q);
		end
		if (9'(start_row_cfg_q) >= 9'(clamp_r)) begin
			start_r = RW'(9'(clamp_r) - 9'd1);
		end else begin
			start_r = RW'(start_row_cfg_q);
		end
		if (9'(start_col_cfg_q) >= 9'(clamp_c)) begin
			start_c = CW'(9'(clamp_c) - 9'd1);
		end else begin
			start_c = CW'(start_col_cfg_q);
		end
	end

	logic [3:0]    cand_ok;
	logic [RW-1:0] cand_r [4];
	logic [CW-1:0] cand_c [4];
	logic [2:0]    n_cand;
	logic [1:0]    k_sel;
	logic [3:0]    dig_sum;
	logic [2:0]    fold1, fold2;
	logic [1:0]    pick_mod3;
	logic [RW-1:0] sel_r;
	logic [CW-1:0] sel_c;
	logic [2:0]    seen;

	always_comb begin
		cand_ok[0] = (9'(walker_row_q) + 9'd1) < 9'(maze_rows_q);
		cand_ok[1] = (9'(walker_col_q) + 9'd1) < 9'(maze_cols_q);
		cand_ok[2] = walker_row_q != '0;
		cand_ok[3] = walker_col_q != '0;
		cand_r[0]  = RW'(walker_row_q + RW'(1));
		cand_c[0]  = walker_col_q;
		cand_r[1]  = walker_row_q;
		cand_c[1]  = CW'(walker_col_q + CW'(1));
		cand_r[2]  = RW'(walker_row_q - RW'(1));
		cand_c[2]  = walker_col_q;
		cand_r[3]  = walker_row_q;
		cand_c[3]  = CW'(walker_col_q - CW'(1));
		n_cand = 3'(cand_ok[0]) + 3'(cand_ok[1]) + 3'(cand_ok[2]) + 3'(cand_ok[3]);

		// pick mod 3 by summing base-4 digits (4 == 1 mod 3)
		dig_sum   = 4'(item.pick[1:0]) + 4'(item.pick[3:2])
		          + 4'(item.pick[5:4]) + 4'(item.pick[7:6]);
		fold1     = 3'(dig_sum[1:0]) + 3'(dig_sum[3:2]);
		fold2     = 3'(fold1[1:0]) + 3'(fold1[2]);
		pick_mod3 = (fold2 >= 3'd3) ? 2'(fold2 - 3'd3) : fold2[1:0];

		case (n_cand)
			3'd2:    k_sel = {1'b0, item.pick[0]};
			3'd3:    k_sel = pick_mod3;
			3'd4:    k_sel = item.pick[1:0];
			default: k_sel = 2'd0;
		endcase

		// k-th in-bounds neighbour in list order
		sel_r = walker_row_q;
		sel_c = walker_col_q;
		seen  = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (cand_ok[i]) begin
				if (seen == 3'(k_sel)) begin
					sel_r = cand_r[i];
					sel_c = cand_c[i];
				end
				seen = seen + 3'd1;
			end
		end
	end

	logic step_done;
	assign step_done = count_q >= total_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1  <= item.mode == MODE_START;
			done_s1   <= step_done;
			move_s1   <= (item.mode != MODE_START) && !step_done && (n_cand != 3'd0);
			size_r_s1 <= clamp_r;
			size_c_s1 <= clamp_c;
			if (item.mode == MODE_START) begin
				tr_s1 <= start_r;
				tc_s1 <= start_c;
			end else if (!step_done && (n_cand != 3'd0)) begin
				tr_s1 <= sel_r;
				tc_s1 <= sel_c;
			end else begin
				tr_s1 <= walker_row_q;
				tc_s1 <= walker_col_q;
			end
		end
	end

	//------------------------------------------------------------------
	// Visited map
	//------------------------------------------------------------------
	logic                ram_we;
	logic [MAX_COLS-1:0] ram_wdata;
	logic [MAX_COLS-1:0] ram_rdata;

	// write in stage 2 lands before the next item's read, so no forwarding is needed
	rwmc_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_visited (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tr_s1),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (sel_r),
		.rdata (ram_rdata)
	);

	//------------------------------------------------------------------
	// Stage 2: check/mark, move walker, load result
	//------------------------------------------------------------------
	logic [MAX_COLS-1:0] col_bit;
	logic [MAX_COLS-1:0] row_word;
	logic                carve;
	logic [CNTW-1:0]     count_d;
	logic [CNTW-1:0]     total_new;
	logic                done_out;
	logic [RW+4:0]       fr_ext, tr_ext;
	logic [CW+5:0]       fc_ext, tc_ext;

	always_comb begin
		col_bit        = '0;
		col_bit[tc_s1] = 1'b1;
		row_word       = row_valid_q[tr_s1] ? ram_rdata : '0;
		carve          = move_s1 && !row_word[tc_s1];
		total_new      = CNTW'(size_r_s1) * CNTW'(size_c_s1);
		count_d        = count_q + CNTW'(carve);
		ram_we         = complete && (start_s1 || carve);
		ram_wdata      = start_s1 ? col_bit : (row_word | col_bit);
		if (start_s1) begin
			done_out = (size_r_s1 == SRW'(1)) && (size_c_s1 == SCW'(1));
		end else if (done_s1) begin
			done_out = 1'b1;
		end else begin
			done_out = count_d >= total_q;
		end
		fr_ext = (RW + 5)'(start_s1 ? tr_s1 : walker_row_q);
		fc_ext = (CW + 6)'(start_s1 ? tc_s1 : walker_col_q);
		tr_ext = (RW + 5)'(tr_s1);
		tc_ext = (CW + 6)'(tc_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maze_rows_q    <= SRW'(RST_ROWS);
			maze_cols_q    <= SCW'(RST_COLS);
			total_q        <= CNTW'(RST_TOTAL);
			count_q        <= '0;
			walker_row_q   <= '0;
			walker_col_q   <= '0;
			row_valid_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (complete) begin
				result_valid_q <= 1'b1;
				walker_row_q   <= tr_s1;
				walker_col_q   <= tc_s1;
				if (start_s1) begin
					maze_rows_q        <= size_r_s1;
					maze_cols_q        <= size_c_s1;
					total_q            <= total_new;
					count_q            <= CNTW'(1);
					row_valid_q        <= '0;
					row_valid_q[tr_s1] <= 1'b1;
				end else if (carve) begin
					count_q            <= count_d;
					row_valid_q[tr_s1] <= 1'b1;
				end
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			result_q.from_row <= fr_ext[4:0];
			result_q.from_col <= fc_ext[5:0];
			result_q.to_row   <= tr_ext[4:0];
			result_q.to_col   <= tc_ext[5:0];
			result_q.carved   <= carve;
			result_q.done_res <= done_out;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	`ASSERT_NEXT(a_accept_to_update, clk, arst_n, accept, state_q == ST_UPDATE, "accepted item did not enter update")
	`ASSERT_PROP(a_count_bound, clk, arst_n, count_q <= total_q, "visited count exceeds grid size")
	`ASSERT_PROP(a_carve_moves, clk, arst_n, !(result_valid_q && result_q.carved) || (result_q.from_row != result_q.to_row) || (result_q.from_col != result_q.to_col), "carve reported without a move")
	`ASSERT_PROP(a_done_full, clk, arst_n, !(result_valid_q && result_q.done_res) || (count_q == total_q), "done reported with cells left")

endmodule
